[src/fwpid_pkg.sv]
// shared types and constants of the four-wheel pid controller
package fwpid_pkg;

   localparam int WHEELS     = 4;
   localparam int WHEEL_W    = 2;
   localparam int DATA_W     = 32;
   localparam int GAIN_W     = 16;
   localparam int BOUND_W    = 31;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 31;
   localparam int MCAND_W    = 48;
   localparam int PROD_W     = 64;
   localparam int SUM_W      = 58;
   localparam int MCNT_W     = 4;

   typedef logic [CSR_IDX_W-1:0] csr_index_type;

   localparam csr_index_type CSR_GAIN_P   = 3'd0;
   localparam csr_index_type CSR_GAIN_I   = 3'd1;
   localparam csr_index_type CSR_GAIN_D   = 3'd2;
   localparam csr_index_type CSR_TICK_SEC = 3'd3;
   localparam csr_index_type CSR_TPS      = 3'd4;
   localparam csr_index_type CSR_INT_MAX  = 3'd5;
   localparam csr_index_type CSR_WARN_LVL = 3'd6;

   localparam logic [GAIN_W-1:0]  TICK_SEC_RST = 16'd655;
   localparam logic [GAIN_W-1:0]  TPS_RST      = 16'd100;
   localparam logic [BOUND_W-1:0] INT_MAX_RST  = 31'd655360;
   localparam logic [BOUND_W-1:0] WARN_LVL_RST = 31'd524288;

   typedef struct packed {
      logic signed [DATA_W-1:0] target_w0;
      logic signed [DATA_W-1:0] target_w1;
      logic signed [DATA_W-1:0] target_w2;
      logic signed [DATA_W-1:0] target_w3;
      logic signed [DATA_W-1:0] measured_w0;
      logic signed [DATA_W-1:0] measured_w1;
      logic signed [DATA_W-1:0] measured_w2;
      logic signed [DATA_W-1:0] measured_w3;
   } req_data_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] drive_w0;
      logic signed [DATA_W-1:0] drive_w1;
      logic signed [DATA_W-1:0] drive_w2;
      logic signed [DATA_W-1:0] drive_w3;
      logic                     integral_warning;
   } rsp_data_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ERR,
      ST_MUL,
      ST_INT,
      ST_DER,
      ST_ACC_D,
      ST_ACC_P,
      ST_ACC_I,
      ST_DONE
   } state_type;

endpackage

[src/fwpid_if.sv]
// valid/ready channel interfaces of the four-wheel pid controller
interface fwpid_req_if;
   logic                       valid;
   logic                       ready;
   fwpid_pkg::req_data_type    data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface fwpid_rsp_if;
   logic                       valid;
   logic                       ready;
   fwpid_pkg::rsp_data_type    data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface fwpid_csr_if;
   logic                                   valid;
   logic                                   ready;
   fwpid_pkg::csr_index_type               index;
   logic [fwpid_pkg::CSR_DATA_W-1:0]       data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

[src/four_wheel_pid_feedforward_top.sv]
// four-wheel velocity pid controller with setpoint feedforward, top level
//
// req_ch carries one item per control tick: four setpoints and four measured
// velocities, signed q16.16. rsp_ch returns one item: four saturated drive
// values and the integral warning flag. csr_ch writes the seven registers
// (gains, tick period and rate, integral clamp, warning level); it is always
// ready and should be written only while the block is idle.
// All products come from one shift-add multiplier that takes one multiplier
// bit per cycle, five products per wheel, wheels in turn. The block takes
// no new item until all four wheels are done; rsp_ch.valid and req_ch.ready
// then rise in the same cycle, once the output register is free.
// The result sits in an output register: the next item is accepted and
// worked on while it waits, and only the hand-over of that next result
// waits for rsp_ch.ready.
// Reset (synchronous, active high) restores the register defaults and clears
// the per-wheel integrals and previous errors.
module four_wheel_pid_feedforward_top (
   input  logic          clock,
   input  logic          reset,
   fwpid_req_if.sink     req_ch,
   fwpid_rsp_if.source   rsp_ch,
   fwpid_csr_if.sink     csr_ch
);

   localparam int DW = fwpid_pkg::DATA_W;
   localparam int MW = fwpid_pkg::MCAND_W;
   localparam int PW = fwpid_pkg::PROD_W;
   localparam int SW = fwpid_pkg::SUM_W;
   localparam int GW = fwpid_pkg::GAIN_W;
   localparam int BW = fwpid_pkg::BOUND_W;
   localparam int NW = fwpid_pkg::WHEELS;

   logic [GW-1:0] gain_p_ff, gain_p_in, gain_i_ff, gain_i_in, gain_d_ff, gain_d_in;
   logic [GW-1:0] tick_sec_ff, tick_sec_in, tps_ff, tps_in;
   logic [BW-1:0] int_max_ff, int_max_in, warn_lvl_ff, warn_lvl_in;

   fwpid_pkg::state_type state_ff, state_in, ret_ff, ret_in;
   logic [fwpid_pkg::WHEEL_W-1:0] wheel_ff, wheel_in;
   logic [fwpid_pkg::MCNT_W-1:0]  cnt_ff, cnt_in;

   logic signed [DW-1:0] target_ff [NW], target_in [NW];
   logic signed [DW-1:0] meas_ff   [NW], meas_in   [NW];
   logic signed [DW-1:0] integ_ff  [NW], integ_in  [NW];
   logic signed [DW-1:0] last_ff   [NW], last_in   [NW];
   logic signed [DW-1:0] drive_ff  [NW], drive_in  [NW];

   logic signed [DW-1:0] err_ff, err_in;
   logic signed [MW-1:0] mcand_ff, mcand_in;
   logic [GW-1:0]        mplr_ff, mplr_in;
   logic signed [PW-1:0] acc_ff, acc_in;
   logic signed [SW-1:0] sum_ff, sum_in;
   logic                 warn_ff, warn_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   fwpid_pkg::rsp_data_type rsp_data_ff, rsp_data_in;

   logic                    accept;
   logic                    out_free;

   logic signed [DW:0]   diff;
   logic signed [DW-1:0] err_sat;
   logic signed [DW+1:0] isum, ilim, inlim, iclamp;
   logic signed [DW+1:0] warn_s;
   logic signed [DW:0]   ddiff;
   logic signed [MW-1:0] deriv;
   logic signed [SW-1:0] term;
   logic signed [SW-1:0] sum_fin;
   logic signed [DW-1:0] drive_sat;

   assign accept       = req_ch.valid && req_ch.ready;
   assign out_free     = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready = (state_ff == fwpid_pkg::ST_IDLE);
   assign csr_ch.ready = 1'b1;
   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.data  = rsp_data_ff;

   // arithmetic shared by the sequencer steps
   always_comb begin
      diff    = {target_ff[0][DW-1], target_ff[0]} - {meas_ff[0][DW-1], meas_ff[0]};
      err_sat = diff[DW-1:0];
      if (diff[DW] != diff[DW-1]) begin
         err_sat = diff[DW] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
      end

      isum  = {{2{integ_ff[0][DW-1]}}, integ_ff[0]}
            + {{2{acc_ff[47]}}, acc_ff[47:16]};
      ilim  = {3'b000, int_max_ff};
      inlim = -ilim;
      priority if (isum > ilim) begin
         iclamp = ilim;
      end else if (isum < inlim) begin
         iclamp = inlim;
      end else begin
         iclamp = isum;
      end
      warn_s = {3'b000, warn_lvl_ff};

      ddiff = {err_ff[DW-1], err_ff} - {last_ff[0][DW-1], last_ff[0]};

      deriv = acc_ff[MW-1:0];
      if (acc_ff[MW] != acc_ff[MW-1]) begin
         deriv = acc_ff[MW] ? {1'b1, {(MW-1){1'b0}}} : {1'b0, {(MW-1){1'b1}}};
      end

      term    = {{(SW-PW+8){acc_ff[PW-1]}}, acc_ff[PW-1:8]};
      sum_fin = sum_ff + term;
      drive_sat = sum_fin[DW-1:0];
      if ((sum_fin[SW-1:DW-1] != '0) && (sum_fin[SW-1:DW-1] != '1)) begin
         drive_sat = sum_fin[SW-1] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         fwpid_pkg::ST_IDLE:  if (accept) state_in = fwpid_pkg::ST_ERR;
         fwpid_pkg::ST_ERR:   state_in = fwpid_pkg::ST_MUL;
         fwpid_pkg::ST_MUL:   if (cnt_ff == '1) state_in = ret_ff;
         fwpid_pkg::ST_INT:   state_in = fwpid_pkg::ST_MUL;
         fwpid_pkg::ST_DER:   state_in = fwpid_pkg::ST_MUL;
         fwpid_pkg::ST_ACC_D: state_in = fwpid_pkg::ST_MUL;
         fwpid_pkg::ST_ACC_P: state_in = fwpid_pkg::ST_MUL;
         fwpid_pkg::ST_ACC_I: begin
            state_in = (wheel_ff == '1) ? fwpid_pkg::ST_DONE : fwpid_pkg::ST_ERR;
         end
         fwpid_pkg::ST_DONE:  if (out_free) state_in = fwpid_pkg::ST_IDLE;
         default:             state_in = fwpid_pkg::ST_IDLE;
      endcase
   end

   // datapath and register writes
   always_comb begin
      gain_p_in   = gain_p_ff;
      gain_i_in   = gain_i_ff;
      gain_d_in   = gain_d_ff;
      tick_sec_in = tick_sec_ff;
      tps_in      = tps_ff;
      int_max_in  = int_max_ff;
      warn_lvl_in = warn_lvl_ff;
      ret_in      = ret_ff;
      wheel_in    = wheel_ff;
      cnt_in      = cnt_ff;
      target_in   = target_ff;
      meas_in     = meas_ff;
      integ_in    = integ_ff;
      last_in     = last_ff;
      drive_in    = drive_ff;
      err_in      = err_ff;
      mcand_in    = mcand_ff;
      mplr_in     = mplr_ff;
      acc_in      = acc_ff;
      sum_in      = sum_ff;
      warn_in     = warn_ff;
      rsp_data_in = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;

      if (csr_ch.valid && csr_ch.ready) begin
         unique case (csr_ch.index)
            fwpid_pkg::CSR_GAIN_P:   gain_p_in   = csr_ch.data[GW-1:0];
            fwpid_pkg::CSR_GAIN_I:   gain_i_in   = csr_ch.data[GW-1:0];
            fwpid_pkg::CSR_GAIN_D:   gain_d_in   = csr_ch.data[GW-1:0];
            fwpid_pkg::CSR_TICK_SEC: tick_sec_in = csr_ch.data[GW-1:0];
            fwpid_pkg::CSR_TPS:      tps_in      = csr_ch.data[GW-1:0];
            fwpid_pkg::CSR_INT_MAX:  int_max_in  = csr_ch.data[BW-1:0];
            fwpid_pkg::CSR_WARN_LVL: warn_lvl_in = csr_ch.data[BW-1:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         fwpid_pkg::ST_IDLE: begin
            if (accept) begin
               target_in[0] = req_ch.data.target_w0;
               target_in[1] = req_ch.data.target_w1;
               target_in[2] = req_ch.data.target_w2;
               target_in[3] = req_ch.data.target_w3;
               meas_in[0]   = req_ch.data.measured_w0;
               meas_in[1]   = req_ch.data.measured_w1;
               meas_in[2]   = req_ch.data.measured_w2;
               meas_in[3]   = req_ch.data.measured_w3;
               warn_in      = 1'b0;
               wheel_in     = '0;
            end
         end
         fwpid_pkg::ST_ERR: begin
            err_in   = err_sat;
            sum_in   = {{(SW-DW){target_ff[0][DW-1]}}, target_ff[0]};
            mcand_in = {{(MW-DW){err_sat[DW-1]}}, err_sat};
            mplr_in  = tick_sec_ff;
            acc_in   = '0;
            cnt_in   = '0;
            ret_in   = fwpid_pkg::ST_INT;
         end
         fwpid_pkg::ST_MUL: begin
            acc_in  = {acc_ff[PW-2:0], 1'b0}
                    + (mplr_ff[GW-1] ? {{(PW-MW){mcand_ff[MW-1]}}, mcand_ff} : '0);
            mplr_in = {mplr_ff[GW-2:0], 1'b0};
            cnt_in  = cnt_ff + 1'b1;
         end
         fwpid_pkg::ST_INT: begin
            integ_in[0] = iclamp[DW-1:0];
            warn_in     = warn_ff || (iclamp >= warn_s);
            mcand_in    = {{(MW-DW-1){ddiff[DW]}}, ddiff};
            mplr_in     = tps_ff;
            acc_in      = '0;
            cnt_in      = '0;
            ret_in      = fwpid_pkg::ST_DER;
         end
         fwpid_pkg::ST_DER: begin
            mcand_in = deriv;
            mplr_in  = gain_d_ff;
            acc_in   = '0;
            cnt_in   = '0;
            ret_in   = fwpid_pkg::ST_ACC_D;
         end
         fwpid_pkg::ST_ACC_D: begin
            sum_in   = sum_fin;
            mcand_in = {{(MW-DW){err_ff[DW-1]}}, err_ff};
            mplr_in  = gain_p_ff;
            acc_in   = '0;
            cnt_in   = '0;
            ret_in   = fwpid_pkg::ST_ACC_P;
         end
         fwpid_pkg::ST_ACC_P: begin
            sum_in   = sum_fin;
            mcand_in = {{(MW-DW){integ_ff[0][DW-1]}}, integ_ff[0]};
            mplr_in  = gain_i_ff;
            acc_in   = '0;
            cnt_in   = '0;
            ret_in   = fwpid_pkg::ST_ACC_I;
         end
         fwpid_pkg::ST_ACC_I: begin
            // rotate per-wheel state so the next wheel sits at entry 0
            for (int i = 0; i < NW - 1; i++) begin
               target_in[i] = target_ff[i+1];
               meas_in[i]   = meas_ff[i+1];
               integ_in[i]  = integ_ff[i+1];
               last_in[i]   = last_ff[i+1];
               drive_in[i]  = drive_ff[i+1];
            end
            integ_in[NW-1] = integ_ff[0];
            last_in[NW-1]  = err_ff;
            drive_in[NW-1] = drive_sat;
            wheel_in       = wheel_ff + 1'b1;
         end
         fwpid_pkg::ST_DONE: begin
            if (out_free) begin
               rsp_data_in.drive_w0         = drive_ff[0];
               rsp_data_in.drive_w1         = drive_ff[1];
               rsp_data_in.drive_w2         = drive_ff[2];
               rsp_data_in.drive_w3         = drive_ff[3];
               rsp_data_in.integral_warning = warn_ff;
               rsp_valid_in                 = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fwpid_pkg::ST_IDLE;
         ret_ff       <= fwpid_pkg::ST_IDLE;
         wheel_ff     <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         gain_p_ff    <= '0;
         gain_i_ff    <= '0;
         gain_d_ff    <= '0;
         tick_sec_ff  <= fwpid_pkg::TICK_SEC_RST;
         tps_ff       <= fwpid_pkg::TPS_RST;
         int_max_ff   <= fwpid_pkg::INT_MAX_RST;
         warn_lvl_ff  <= fwpid_pkg::WARN_LVL_RST;
         for (int i = 0; i < NW; i++) begin
            integ_ff[i] <= '0;
            last_ff[i]  <= '0;
         end
      end else begin
         state_ff     <= state_in;
         ret_ff       <= ret_in;
         wheel_ff     <= wheel_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         gain_p_ff    <= gain_p_in;
         gain_i_ff    <= gain_i_in;
         gain_d_ff    <= gain_d_in;
         tick_sec_ff  <= tick_sec_in;
         tps_ff       <= tps_in;
         int_max_ff   <= int_max_in;
         warn_lvl_ff  <= warn_lvl_in;
         integ_ff     <= integ_in;
         last_ff      <= last_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      target_ff   <= target_in;
      meas_ff     <= meas_in;
      drive_ff    <= drive_in;
      err_ff      <= err_in;
      mcand_ff    <= mcand_in;
      mplr_ff     <= mplr_in;
      acc_ff      <= acc_in;
      sum_ff      <= sum_in;
      warn_ff     <= warn_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule
